/* rtl/ddrw_pkg.sv */
`default_nettype none
package ddrw_pkg;

    localparam int unsigned PAW = 5;

    typedef struct packed {
        logic signed [31:0] target_linear;
        logic signed [31:0] target_angular;
        logic [31:0]        now_us;
    } s_word_t;

    typedef struct packed {
        logic signed [31:0] right_command;
        logic signed [31:0] left_command;
    } m_word_t;

    typedef struct packed {
        logic [30:0] radius_len;
        logic [30:0] track_width;
        logic [30:0] max_wheel_speed;
        logic [30:0] max_linear_speed;
        logic [30:0] max_angular_speed;
        logic [30:0] max_linear_accel;
        logic [30:0] max_angular_accel;
        logic [19:0] max_step_time;
    } cfg_t;

    localparam logic [2:0] REG_RADIUS            = 3'd0;
    localparam logic [2:0] REG_TRACK_WIDTH       = 3'd1;
    localparam logic [2:0] REG_MAX_WHEEL_SPEED   = 3'd2;
    localparam logic [2:0] REG_MAX_LINEAR_SPEED  = 3'd3;
    localparam logic [2:0] REG_MAX_ANGULAR_SPEED = 3'd4;
    localparam logic [2:0] REG_MAX_LINEAR_ACCEL  = 3'd5;
    localparam logic [2:0] REG_MAX_ANGULAR_ACCEL = 3'd6;
    localparam logic [2:0] REG_MAX_STEP_TIME     = 3'd7;

    localparam cfg_t CFG_RESET = '{
        radius_len:        31'd3277,
        track_width:       31'd19661,
        max_wheel_speed:   31'd1310720,
        max_linear_speed:  31'd65536,
        max_angular_speed: 31'd131072,
        max_linear_accel:  31'd65536,
        max_angular_accel: 31'd65536,
        max_step_time:     20'd10000
    };

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic       start;
        logic       op;
        logic [6:0] steps;
    } sau_req_t;

    localparam logic [6:0]  MUL_STEPS    = 7'd33;
    localparam logic [6:0]  RATIO_STEPS  = 7'd32;
    localparam logic [6:0]  LONG_STEPS   = 7'd64;
    localparam logic [63:0] USEC_PER_SEC = 64'd1000000;
    localparam logic [32:0] UNITY        = 33'h1_0000_0000;

endpackage
`default_nettype wire

/* rtl/ddrw_cfg.sv */
`default_nettype none
module ddrw_cfg (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ddrw_pkg::PAW-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output ddrw_pkg::cfg_t           cfg
);
    import ddrw_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] idx;

    assign idx    = paddr[PAW-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                REG_RADIUS:            cfg_next.radius_len        = pwdata[30:0];
                REG_TRACK_WIDTH:       cfg_next.track_width       = pwdata[30:0];
                REG_MAX_WHEEL_SPEED:   cfg_next.max_wheel_speed   = pwdata[30:0];
                REG_MAX_LINEAR_SPEED:  cfg_next.max_linear_speed  = pwdata[30:0];
                REG_MAX_ANGULAR_SPEED: cfg_next.max_angular_speed = pwdata[30:0];
                REG_MAX_LINEAR_ACCEL:  cfg_next.max_linear_accel  = pwdata[30:0];
                REG_MAX_ANGULAR_ACCEL: cfg_next.max_angular_accel = pwdata[30:0];
                REG_MAX_STEP_TIME:     cfg_next.max_step_time     = pwdata[19:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RADIUS:            prdata = {1'b0, cfg_reg.radius_len};
            REG_TRACK_WIDTH:       prdata = {1'b0, cfg_reg.track_width};
            REG_MAX_WHEEL_SPEED:   prdata = {1'b0, cfg_reg.max_wheel_speed};
            REG_MAX_LINEAR_SPEED:  prdata = {1'b0, cfg_reg.max_linear_speed};
            REG_MAX_ANGULAR_SPEED: prdata = {1'b0, cfg_reg.max_angular_speed};
            REG_MAX_LINEAR_ACCEL:  prdata = {1'b0, cfg_reg.max_linear_accel};
            REG_MAX_ANGULAR_ACCEL: prdata = {1'b0, cfg_reg.max_angular_accel};
            REG_MAX_STEP_TIME:     prdata = {12'd0, cfg_reg.max_step_time};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/ddrw_sau.sv */
`default_nettype none
module ddrw_sau (
    input  logic               aclk,
    input  logic               aresetn,
    input  ddrw_pkg::sau_req_t req,
    input  logic [32:0]        op_a,
    input  logic [32:0]        op_b,
    input  logic [63:0]        rem_init,
    input  logic [63:0]        quo_init,
    input  logic [63:0]        divisor,
    output logic               done,
    output logic [65:0]        prod,
    output logic [63:0]        quo
);
    import ddrw_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [65:0] p_reg, p_next;
    logic [32:0] a_reg, a_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] d_reg, d_next;
    logic [33:0] sum;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    assign sum   = {1'b0, p_reg[65:33]} + (p_reg[0] ? {1'b0, a_reg} : 34'd0);
    assign trial = {r_reg, q_reg[63]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    assign done = done_reg;
    assign prod = p_reg;
    assign quo  = q_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = req.steps;
            p_next    = {33'd0, op_b};
            a_next    = op_a;
            r_next    = rem_init;
            q_next    = quo_init;
            d_next    = divisor;
        end else if (busy_reg) begin
            if (op_reg == OP_MUL) begin
                p_next = {sum, p_reg[32:1]};
            end else begin
                r_next = ge ? diff[63:0] : trial[63:0];
                q_next = {q_reg[62:0], ge};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= 7'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
        a_reg <= a_next;
        r_reg <= r_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

endmodule
`default_nettype wire

/* rtl/diff_drive_ramped_wheel_command.sv */
`default_nettype none
// Turns each tick's target linear and angular speed into right and left wheel
// commands, scaling the targets into the speed limits and ramping the stored
// goals by at most acceleration times the elapsed time. All work runs through
// one shared unit that multiplies or divides one bit per cycle. One item is in
// work at a time; a finished word waits in the output register while the next
// word is accepted.
module diff_drive_ramped_wheel_command (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ddrw_pkg::s_word_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output ddrw_pkg::m_word_t        m_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ddrw_pkg::PAW-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import ddrw_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_NUM_MUL  = 4'd1;
    localparam logic [3:0] ST_NUM_SUM  = 4'd2;
    localparam logic [3:0] ST_WLIM     = 4'd3;
    localparam logic [3:0] ST_LIM      = 4'd4;
    localparam logic [3:0] ST_LIM_DIV  = 4'd5;
    localparam logic [3:0] ST_STEP_MUL = 4'd6;
    localparam logic [3:0] ST_STEP_DIV = 4'd7;
    localparam logic [3:0] ST_SCALE    = 4'd8;
    localparam logic [3:0] ST_CMD_DIV  = 4'd9;
    localparam logic [3:0] ST_OUT      = 4'd10;

    function automatic logic [32:0] mag32(input logic [31:0] x);
        logic [32:0] e;
        e = {x[31], x};
        mag32 = x[31] ? (33'd0 - e) : e;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] x);
        mag64 = x[63] ? (64'd0 - x) : x;
    endfunction

    cfg_t     cfg;
    sau_req_t req;
    logic        sau_done;
    logic [65:0] prod;
    logic [63:0] quo;
    logic [32:0] op_a, op_b;
    logic [63:0] rem_init, quo_init, divisor;

    logic [3:0]  state_reg, state_next;
    logic        issued_reg, issued_next;
    logic        sel_reg, sel_next;
    logic [1:0]  cand_reg, cand_next;
    logic        pass_reg, pass_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] lin_ramp_reg, lin_ramp_next;
    logic [31:0] ang_ramp_reg, ang_ramp_next;
    logic [31:0] last_stamp_reg, last_stamp_next;
    logic [31:0] v_reg, v_next;
    logic [31:0] w_reg, w_next;
    logic [19:0] dt_reg, dt_next;
    logic [63:0] nr_reg, nr_next;
    logic [63:0] nl_reg, nl_next;
    logic [63:0] wlim_reg, wlim_next;
    logic [32:0] f_reg, f_next;
    logic [32:0] lstep_reg, lstep_next;
    logic [32:0] astep_reg, astep_next;
    logic [31:0] right_reg, right_next;
    logic [31:0] left_reg, left_next;
    m_word_t     m_data_reg, m_data_next;

    logic [31:0] r2;
    logic [31:0] lin_src, ang_src;
    logic [32:0] ang_mag, v_mag, w_mag;
    logic [63:0] ang_term, lin_term;
    logic [63:0] cand_lim, cand_mag;
    logic [31:0] elapsed;
    logic [32:0] smag;
    logic        t_neg;
    logic [34:0] scaled, ramp_cur, step_cur, ramp_hi, ramp_lo, ramp_cap, ramp_new;
    logic [63:0] cmd_num;
    logic [31:0] cmd_sat;

    ddrw_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddrw_sau u_sau (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .op_a     (op_a),
        .op_b     (op_b),
        .rem_init (rem_init),
        .quo_init (quo_init),
        .divisor  (divisor),
        .done     (sau_done),
        .prod     (prod),
        .quo      (quo)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign r2      = {(cfg.radius_len == 31'd0) ? 31'd1 : cfg.radius_len, 1'b0};
    assign lin_src = pass_reg ? lin_ramp_reg : v_reg;
    assign ang_src = pass_reg ? ang_ramp_reg : w_reg;
    assign ang_mag = mag32(ang_src);
    assign v_mag   = mag32(v_reg);
    assign w_mag   = mag32(w_reg);
    assign ang_term = ang_src[31] ? (64'd0 - prod[63:0]) : prod[63:0];
    assign lin_term = {{15{lin_src[31]}}, lin_src, 17'd0};
    assign elapsed  = s_data.now_us - last_stamp_reg;

    always_comb begin
        unique case (cand_reg)
            2'd0: begin
                cand_lim = wlim_reg;
                cand_mag = mag64(nr_reg);
            end
            2'd1: begin
                cand_lim = wlim_reg;
                cand_mag = mag64(nl_reg);
            end
            2'd2: begin
                cand_lim = {33'd0, cfg.max_linear_speed};
                cand_mag = {31'd0, v_mag};
            end
            2'd3: begin
                cand_lim = {33'd0, cfg.max_angular_speed};
                cand_mag = {31'd0, w_mag};
            end
        endcase
    end

    assign smag     = prod[64:32];
    assign t_neg    = sel_reg ? w_reg[31] : v_reg[31];
    assign scaled   = t_neg ? (35'd0 - {2'b0, smag}) : {2'b0, smag};
    assign ramp_cur = sel_reg ? {{3{ang_ramp_reg[31]}}, ang_ramp_reg}
                              : {{3{lin_ramp_reg[31]}}, lin_ramp_reg};
    assign step_cur = {2'b0, sel_reg ? astep_reg : lstep_reg};
    assign ramp_hi  = ramp_cur + step_cur;
    assign ramp_lo  = ramp_cur - step_cur;
    assign ramp_cap = ($signed(scaled) < $signed(ramp_hi)) ? scaled : ramp_hi;
    assign ramp_new = ($signed(ramp_cap) > $signed(ramp_lo)) ? ramp_cap : ramp_lo;

    assign cmd_num = sel_reg ? nl_reg : nr_reg;

    always_comb begin
        if (cmd_num[63]) begin
            cmd_sat = (quo > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
        end else begin
            cmd_sat = (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end
    end

    always_comb begin
        state_next      = state_reg;
        issued_next     = issued_reg;
        sel_next        = sel_reg;
        cand_next       = cand_reg;
        pass_next       = pass_reg;
        m_valid_next    = m_valid_reg;
        lin_ramp_next   = lin_ramp_reg;
        ang_ramp_next   = ang_ramp_reg;
        last_stamp_next = last_stamp_reg;
        v_next          = v_reg;
        w_next          = w_reg;
        dt_next         = dt_reg;
        nr_next         = nr_reg;
        nl_next         = nl_reg;
        wlim_next       = wlim_reg;
        f_next          = f_reg;
        lstep_next      = lstep_reg;
        astep_next      = astep_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        m_data_next     = m_data_reg;
        req             = '0;
        op_a            = '0;
        op_b            = '0;
        rem_init        = '0;
        quo_init        = '0;
        divisor         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    v_next          = s_data.target_linear;
                    w_next          = s_data.target_angular;
                    dt_next         = (elapsed > {12'd0, cfg.max_step_time})
                                      ? cfg.max_step_time : elapsed[19:0];
                    last_stamp_next = s_data.now_us;
                    pass_next       = 1'b0;
                    state_next      = ST_NUM_MUL;
                end
            end
            ST_NUM_MUL: begin
                req.op    = OP_MUL;
                req.steps = MUL_STEPS;
                op_a      = ang_mag;
                op_b      = {2'b0, cfg.track_width};
                if (!issued_reg) begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end else if (sau_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_NUM_SUM;
                end
            end
            ST_NUM_SUM: begin
                nr_next    = lin_term + ang_term;
                nl_next    = lin_term - ang_term;
                sel_next   = 1'b0;
                state_next = pass_reg ? ST_CMD_DIV : ST_WLIM;
            end
            ST_WLIM: begin
                req.op    = OP_MUL;
                req.steps = MUL_STEPS;
                op_a      = {2'b0, cfg.max_wheel_speed};
                op_b      = {1'b0, r2};
                if (!issued_reg) begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end else if (sau_done) begin
                    issued_next = 1'b0;
                    wlim_next   = prod[63:0];
                    f_next      = UNITY;
                    cand_next   = 2'd0;
                    state_next  = ST_LIM;
                end
            end
            ST_LIM: begin
                if (cand_mag > cand_lim) begin
                    state_next = ST_LIM_DIV;
                end else begin
                    cand_next = cand_reg + 2'd1;
                    if (cand_reg == 2'd3) begin
                        sel_next   = 1'b0;
                        state_next = ST_STEP_MUL;
                    end
                end
            end
            ST_LIM_DIV: begin
                req.op    = OP_DIV;
                req.steps = RATIO_STEPS;
                rem_init  = cand_lim;
                divisor   = cand_mag;
                if (!issued_reg) begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end else if (sau_done) begin
                    issued_next = 1'b0;
                    if ({1'b0, quo[31:0]} < f_reg) begin
                        f_next = {1'b0, quo[31:0]};
                    end
                    cand_next = cand_reg + 2'd1;
                    if (cand_reg == 2'd3) begin
                        sel_next   = 1'b0;
                        state_next = ST_STEP_MUL;
                    end else begin
                        state_next = ST_LIM;
                    end
                end
            end
            ST_STEP_MUL: begin
                req.op    = OP_MUL;
                req.steps = MUL_STEPS;
                op_a      = {2'b0, sel_reg ? cfg.max_angular_accel : cfg.max_linear_accel};
                op_b      = {13'd0, dt_reg};
                if (!issued_reg) begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end else if (sau_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_STEP_DIV;
                end
            end
            ST_STEP_DIV: begin
                req.op    = OP_DIV;
                req.steps = LONG_STEPS;
                quo_init  = prod[63:0];
                divisor   = USEC_PER_SEC;
                if (!issued_reg) begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end else if (sau_done) begin
                    issued_next = 1'b0;
                    if (sel_reg) begin
                        astep_next = quo[32:0];
                    end else begin
                        lstep_next = quo[32:0];
                    end
                    sel_next   = !sel_reg;
                    state_next = sel_reg ? ST_SCALE : ST_STEP_MUL;
                end
            end
            ST_SCALE: begin
                req.op    = OP_MUL;
                req.steps = MUL_STEPS;
                op_a      = sel_reg ? w_mag : v_mag;
                op_b      = f_reg;
                if (!issued_reg) begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end else if (sau_done) begin
                    issued_next = 1'b0;
                    if (sel_reg) begin
                        ang_ramp_next = ramp_new[31:0];
                        pass_next     = 1'b1;
                        state_next    = ST_NUM_MUL;
                    end else begin
                        lin_ramp_next = ramp_new[31:0];
                    end
                    sel_next = !sel_reg;
                end
            end
            ST_CMD_DIV: begin
                req.op    = OP_DIV;
                req.steps = LONG_STEPS;
                quo_init  = mag64(cmd_num);
                divisor   = {32'd0, r2};
                if (!issued_reg) begin
                    req.start   = 1'b1;
                    issued_next = 1'b1;
                end else if (sau_done) begin
                    issued_next = 1'b0;
                    if (sel_reg) begin
                        left_next  = cmd_sat;
                        state_next = ST_OUT;
                    end else begin
                        right_next = cmd_sat;
                    end
                    sel_next = !sel_reg;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.right_command = right_reg;
                    m_data_next.left_command  = left_reg;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issued_reg     <= 1'b0;
            sel_reg        <= 1'b0;
            cand_reg       <= 2'd0;
            pass_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            lin_ramp_reg   <= 32'd0;
            ang_ramp_reg   <= 32'd0;
            last_stamp_reg <= 32'd0;
        end else begin
            state_reg      <= state_next;
            issued_reg     <= issued_next;
            sel_reg        <= sel_next;
            cand_reg       <= cand_next;
            pass_reg       <= pass_next;
            m_valid_reg    <= m_valid_next;
            lin_ramp_reg   <= lin_ramp_next;
            ang_ramp_reg   <= ang_ramp_next;
            last_stamp_reg <= last_stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        w_reg      <= w_next;
        dt_reg     <= dt_next;
        nr_reg     <= nr_next;
        nl_reg     <= nl_next;
        wlim_reg   <= wlim_next;
        f_reg      <= f_next;
        lstep_reg  <= lstep_next;
        astep_reg  <= astep_next;
        right_reg  <= right_next;
        left_reg   <= left_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

/* rtl/ddrw_chk.sv */
`default_nettype none
module ddrw_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ddrw_pkg::m_word_t m_data
);

    // A word held back by the sink keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    a_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a word in work");

endmodule

bind diff_drive_ramped_wheel_command ddrw_chk u_ddrw_chk (.*);
`default_nettype wire
